### sv/page_framebuffer_draw_top_macros.svh
// Assertion macros shared by the framebuffer RTL.
`ifndef PAGE_FRAMEBUFFER_DRAW_TOP_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfb check failed");

// Next-cycle implication, checked outside reset.
`define PFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfb check failed");

`endif

### sv/pfb_pkg.sv
package pfb_pkg;

    localparam int SCREEN_WIDTH  = 84;
    localparam int SCREEN_HEIGHT = 48;
    localparam int PAGE_ROWS     = 8;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_CLR   = 3'd1;
    localparam logic [2:0] OP_DRAW  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [1:0] ATTR_INVERSE   = 2'd1;
    localparam logic [1:0] ATTR_UNDERLINE = 2'd2;

    localparam logic [7:0] INVERT_MASK    = 8'hff;
    localparam logic [7:0] UNDERLINE_MASK = 8'b1000_0000;

    // Kind of read-modify-write applied to a fetched byte
    localparam logic [1:0] MK_SET  = 2'd0;
    localparam logic [1:0] MK_CLR  = 2'd1;
    localparam logic [1:0] MK_DRAW = 2'd2;

    typedef struct packed {
        logic       clear;
        logic       lower;
        logic [1:0] kind;
        logic [2:0] sh;
        logic [7:0] col;
    } mctl_t;

endpackage

### sv/pfb_ram.sv
module pfb_ram #(
    parameter int DEPTH  = 504,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/pfb_merge.sv
module pfb_merge (
    input  pfb_pkg::mctl_t mctl,
    input  logic [7:0]     rdata,
    output logic [7:0]     wdata
);

    logic [15:0] shifted;
    logic [7:0]  hi_mask;
    logic [7:0]  bit_mask;

    always_comb
    begin
        shifted  = {8'd0, mctl.col} << mctl.sh;
        hi_mask  = 8'hff << mctl.sh;
        bit_mask = 8'd1 << mctl.sh;
        if (mctl.clear)
        begin
            wdata = 8'd0;
        end
        else
        begin
            case (mctl.kind)
                pfb_pkg::MK_SET:  wdata = rdata | bit_mask;
                pfb_pkg::MK_CLR:  wdata = rdata & ~bit_mask;
                pfb_pkg::MK_DRAW:
                begin
                    // upper page takes the shifted column, lower page the spill
                    if (mctl.lower)
                    begin
                        wdata = (rdata & hi_mask) | shifted[15:8];
                    end
                    else
                    begin
                        wdata = (rdata & ~hi_mask) | shifted[7:0];
                    end
                end
                default:          wdata = rdata;
            endcase
        end
    end

endmodule

### sv/pfb_ctrl.sv
`include "page_framebuffer_draw_top_macros.svh"

module pfb_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [2:0]                 op,
    input  logic [7:0]                 x_pos,
    input  logic [7:0]                 y_pos,
    input  logic [7:0]                 glyph_column,
    input  logic [1:0]                 attribute,
    input  logic [8:0]                 read_index,
    output logic                       busy,
    output logic                       ram_we,
    output logic [pfb_pkg::ADDR_W-1:0] ram_addr,
    output pfb_pkg::mctl_t             mctl,
    output logic                       rd_capture,
    output logic                       rd_ok
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_WR_A   = 3'd2;
    localparam logic [2:0] ST_RD_B   = 3'd3;
    localparam logic [2:0] ST_WR_B   = 3'd4;
    localparam logic [2:0] ST_RD_OUT = 3'd5;

    localparam logic [pfb_pkg::ADDR_W-1:0] LAST_ADDR =
        pfb_pkg::ADDR_W'(pfb_pkg::STORE_DEPTH - 1);
    localparam logic [pfb_pkg::ADDR_W-1:0] PAGE_STEP =
        pfb_pkg::ADDR_W'(pfb_pkg::SCREEN_WIDTH);

    logic [2:0]                 state_reg, state_next;
    logic [pfb_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [pfb_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [2:0]                 sh_reg, sh_next;
    logic [7:0]                 col_reg, col_next;
    logic                       second_reg, second_next;
    logic                       rd_ok_reg, rd_ok_next;

    logic                       accept;
    logic [7:0]                 page;
    int                         idx_full;
    logic [pfb_pkg::ADDR_W-1:0] idx_a;
    logic                       on_screen;
    logic                       spill;
    logic [7:0]                 col_attr;
    logic [1:0]                 kind_in;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_comb
    begin
        page      = 8'(y_pos / pfb_pkg::PAGE_ROWS);
        idx_full  = int'(x_pos) + pfb_pkg::SCREEN_WIDTH * int'(page);
        idx_a     = pfb_pkg::ADDR_W'(idx_full);
        on_screen = (int'(x_pos) < pfb_pkg::SCREEN_WIDTH)
                 && (int'(y_pos) < pfb_pkg::SCREEN_HEIGHT);
        spill     = (y_pos[2:0] != 3'd0)
                 && (int'(y_pos) + pfb_pkg::PAGE_ROWS < pfb_pkg::SCREEN_HEIGHT);
        case (attribute)
            pfb_pkg::ATTR_INVERSE:   col_attr = glyph_column ^ pfb_pkg::INVERT_MASK;
            pfb_pkg::ATTR_UNDERLINE: col_attr = glyph_column | pfb_pkg::UNDERLINE_MASK;
            default:                 col_attr = glyph_column;
        endcase
        case (op)
            pfb_pkg::OP_SET: kind_in = pfb_pkg::MK_SET;
            pfb_pkg::OP_CLR: kind_in = pfb_pkg::MK_CLR;
            default:         kind_in = pfb_pkg::MK_DRAW;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        addr_next    = addr_reg;
        kind_next    = kind_reg;
        sh_next      = sh_reg;
        col_next     = col_reg;
        second_next  = second_reg;
        rd_ok_next   = rd_ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next   = idx_a;
                    kind_next   = kind_in;
                    sh_next     = y_pos[2:0];
                    col_next    = col_attr;
                    second_next = (op == pfb_pkg::OP_DRAW) && spill;
                    rd_ok_next  = (int'(read_index) < pfb_pkg::STORE_DEPTH);
                    case (op)
                        pfb_pkg::OP_SET,
                        pfb_pkg::OP_CLR,
                        pfb_pkg::OP_DRAW:
                        begin
                            if (on_screen)
                            begin
                                state_next = ST_WR_A;
                            end
                        end
                        pfb_pkg::OP_READ:  state_next = ST_RD_OUT;
                        pfb_pkg::OP_CLEAR:
                        begin
                            state_next   = ST_CLEAR;
                            clr_cnt_next = '0;
                        end
                        default:           state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR_A:
            begin
                if (second_reg)
                begin
                    addr_next  = addr_reg + PAGE_STEP;
                    state_next = ST_RD_B;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_B:   state_next = ST_WR_B;
            ST_WR_B:   state_next = ST_IDLE;
            ST_RD_OUT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        kind_reg   <= kind_next;
        sh_reg     <= sh_next;
        col_reg    <= col_next;
        second_reg <= second_next;
        rd_ok_reg  <= rd_ok_next;
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (op == pfb_pkg::OP_READ)
                begin
                    ram_addr = pfb_pkg::ADDR_W'(read_index);
                end
                else
                begin
                    ram_addr = idx_a;
                end
            end
            ST_CLEAR: ram_addr = clr_cnt_reg;
            default:  ram_addr = addr_reg;
        endcase
    end

    assign ram_we     = (state_reg == ST_CLEAR) || (state_reg == ST_WR_A)
                     || (state_reg == ST_WR_B);
    assign rd_capture = (state_reg == ST_RD_OUT);
    assign rd_ok      = rd_ok_reg;

    assign mctl.clear = (state_reg == ST_CLEAR);
    assign mctl.lower = (state_reg == ST_WR_B);
    assign mctl.kind  = kind_reg;
    assign mctl.sh    = sh_reg;
    assign mctl.col   = col_reg;

    `PFB_ASSERT_IMPL(a_we_in_range, clk, rst_n, ram_we, int'(ram_addr) < pfb_pkg::STORE_DEPTH)
    `PFB_ASSERT_IMPL(a_lower_after_read, clk, rst_n, state_reg == ST_WR_B, $past(state_reg) == ST_RD_B)
    `PFB_ASSERT_NEXT(a_second_from_spill, clk, rst_n, (state_reg == ST_WR_A) && !second_reg, state_reg == ST_IDLE)

endmodule

### sv/page_framebuffer_draw_top.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+-----------------------------
// command   | op, x_pos, y_pos, glyph_column, attribute,         | beat taken when start && !busy
//           | read_index                                         |
// result    | read_data                                          | beat on result_valid, 1 cycle
//
// Steps: set/clear pixel, single-page column draw and byte read do one fetch
// from the single-port pixel store, then one write or capture; a column that
// spills into the page below then fetches and writes back the byte below too.
// Clear-all walks the store, one byte a cycle. Dropped ops (off screen, unused
// codes) are taken without raising busy.
// Reset: busy stays high for a clearing pass that zeroes the store.
// A read result appears in the same cycle as the block drops busy again; the
// receiver cannot stall it. The next command only enters after the previous
// write-back, so read-modify-write never overlaps on the same byte.
`include "page_framebuffer_draw_top_macros.svh"

module page_framebuffer_draw_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] op,
    input  logic [7:0] x_pos,
    input  logic [7:0] y_pos,
    input  logic [7:0] glyph_column,
    input  logic [1:0] attribute,
    input  logic [8:0] read_index,
    output logic       result_valid,
    output logic [7:0] read_data
);

    logic                       ram_we;
    logic [pfb_pkg::ADDR_W-1:0] ram_addr;
    logic [7:0]                 ram_wdata;
    logic [7:0]                 ram_rdata;
    pfb_pkg::mctl_t             mctl;
    logic                       rd_capture;
    logic                       rd_ok;

    logic                       result_valid_reg, result_valid_next;
    logic [7:0]                 read_data_reg, read_data_next;

    // Sequencer: accepts commands, steps the fetch/write-back and clear sweep
    pfb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .op           (op),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .glyph_column (glyph_column),
        .attribute    (attribute),
        .read_index   (read_index),
        .busy         (busy),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .mctl         (mctl),
        .rd_capture   (rd_capture),
        .rd_ok        (rd_ok)
    );

    // Modify stage: merge pixel, column or spill into the fetched byte
    pfb_merge u_merge (
        .mctl  (mctl),
        .rdata (ram_rdata),
        .wdata (ram_wdata)
    );

    // Pixel store: one port, registered read
    pfb_ram #(
        .DEPTH  (pfb_pkg::STORE_DEPTH),
        .WIDTH  (8),
        .ADDR_W (pfb_pkg::ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Capture the fetched byte; force zero for an index past the store
    always_comb
    begin
        result_valid_next = rd_capture;
        read_data_next    = read_data_reg;
        if (rd_capture)
        begin
            read_data_next = rd_ok ? ram_rdata : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
    end

    assign result_valid = result_valid_reg;
    assign read_data    = read_data_reg;

    `PFB_ASSERT_NEXT(a_read_gives_beat, clk, rst_n, start && !busy && (op == pfb_pkg::OP_READ), ##1 result_valid)
    `PFB_ASSERT_NEXT(a_single_beat, clk, rst_n, result_valid, !result_valid)

endmodule

### sim/page_framebuffer_draw_checker.sv
`timescale 1ns / 1ps

module page_framebuffer_draw_checker
    import pfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [2:0] op,
    input  logic [7:0] x_pos,
    input  logic [7:0] y_pos,
    input  logic [7:0] glyph_column,
    input  logic [1:0] attribute,
    input  logic [8:0] read_index,
    input  logic       result_valid,
    input  logic [7:0] read_data,
    output int         errors,
    output int         pending,
    output int         reads_checked
);

    typedef struct packed {
        logic [8:0] index;
        logic [7:0] data;
    } readback_t;

    logic [7:0] frame_bytes [STORE_DEPTH];
    readback_t  expected_reads [$];

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0d ns] mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        readback_t  want;
        logic [7:0] col;
        logic [7:0] hi_mask;
        logic [7:0] lo_mask;
        logic       on_screen;
        int         idx;
        int         sh;

        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                frame_bytes[i] = '0;
            expected_reads.delete();
            pending = 0;
        end
        else
        begin
            // Results are ordered, so retire the oldest read first
            if (result_valid)
            begin
                if (expected_reads.size() == 0)
                    report_mismatch($sformatf("read_data %02h with no read outstanding",
                                              read_data));
                else
                begin
                    want = expected_reads.pop_front();
                    reads_checked++;
                    if (read_data !== want.data)
                        report_mismatch($sformatf("byte %0d read %02h, predicted %02h",
                                                  want.index, read_data, want.data));
                end
            end

            if (start && !busy)
            begin
                on_screen = (x_pos < SCREEN_WIDTH) && (y_pos < SCREEN_HEIGHT);
                idx = x_pos + SCREEN_WIDTH * (y_pos / PAGE_ROWS);
                sh = y_pos % PAGE_ROWS;
                case (op)
                    OP_SET:
                        if (on_screen)
                            frame_bytes[idx] = frame_bytes[idx] | (8'd1 << sh);
                    OP_CLR:
                        if (on_screen)
                            frame_bytes[idx] = frame_bytes[idx] & ~(8'd1 << sh);
                    OP_DRAW:
                        if (on_screen)
                        begin
                            col = glyph_column;
                            if (attribute == ATTR_INVERSE)
                                col = col ^ INVERT_MASK;
                            else if (attribute == ATTR_UNDERLINE)
                                col = col | UNDERLINE_MASK;
                            hi_mask = 8'hff << sh;
                            frame_bytes[idx] = (frame_bytes[idx] & ~hi_mask)
                                             | ((col << sh) & hi_mask);
                            // Spill into the page below, never past the last page
                            if (sh != 0 && y_pos + PAGE_ROWS < SCREEN_HEIGHT)
                            begin
                                lo_mask = 8'hff >> (PAGE_ROWS - sh);
                                frame_bytes[idx + SCREEN_WIDTH] =
                                    (frame_bytes[idx + SCREEN_WIDTH] & ~lo_mask)
                                    | ((col >> (PAGE_ROWS - sh)) & lo_mask);
                            end
                        end
                    OP_READ:
                    begin
                        want.index = read_index;
                        want.data = (read_index < STORE_DEPTH) ? frame_bytes[read_index]
                                                               : 8'h00;
                        expected_reads.push_back(want);
                    end
                    OP_CLEAR:
                        for (int i = 0; i < STORE_DEPTH; i++)
                            frame_bytes[i] = '0;
                    default:
                        ;
                endcase
            end
            pending = expected_reads.size();
        end
    end

endmodule

### sim/tb_page_framebuffer_draw_top.sv
`timescale 1ns / 1ps

module tb_page_framebuffer_draw_top;
    import pfb_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0] ATTR_NORMAL = 2'd0;
    localparam logic [1:0] ATTR_SPARE  = 2'd3;

    localparam int TARGET_BEATS = 950;
    // Sized well above the worst case: long gaps, clear-alls, the reset sweep
    localparam int CYCLE_LIMIT  = 500000;
    // Covers a trailing clear-all walking the whole store
    localparam int DRAIN_CYCLES = 520;
    localparam int GLYPH_WIDTH  = 5;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       start        = 1'b0;
    logic [2:0] op           = '0;
    logic [7:0] x_pos        = '0;
    logic [7:0] y_pos        = '0;
    logic [7:0] glyph_column = '0;
    logic [1:0] attribute    = '0;
    logic [8:0] read_index   = '0;
    logic       busy;
    logic       result_valid;
    logic [7:0] read_data;

    int errors;
    int pending;
    int reads_checked;
    int cycle_count;

    // Beat tallies for the closing summary
    int n_pixel;
    int n_draw;
    int n_read;
    int n_clear;
    int n_ignored;
    int useful_beats;
    int last_index;
    logic burst = 1'b0;   // hold start high back to back while set

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    page_framebuffer_draw_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .x_pos        (x_pos),
        .y_pos        (y_pos),
        .glyph_column (glyph_column),
        .attribute    (attribute),
        .read_index   (read_index),
        .result_valid (result_valid),
        .read_data    (read_data)
    );

    page_framebuffer_draw_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .x_pos         (x_pos),
        .y_pos         (y_pos),
        .glyph_column  (glyph_column),
        .attribute     (attribute),
        .read_index    (read_index),
        .result_valid  (result_valid),
        .read_data     (read_data),
        .errors        (errors),
        .pending       (pending),
        .reads_checked (reads_checked)
    );

    // Watchdog: abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reads outstanding", cycle_count, pending);
            $display("page_framebuffer_draw_top test failed");
            $finish;
        end
    end

    // Mostly on screen, sometimes anywhere in the 8-bit range to hit clipping
    function automatic logic [7:0] pick_coord(input int span);
        if ($urandom_range(0, 99) < 90)
            return 8'($urandom_range(0, span - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // Drive one command beat at a rising edge and hold it until the block takes it.
    // Call only right after a rising edge; returns at the edge that took the beat.
    task automatic issue(input logic [2:0] c_op, input logic [7:0] cx, input logic [7:0] cy,
                         input logic [7:0] ccol, input logic [1:0] cattr,
                         input logic [8:0] cidx);
        logic hit;
        op <= c_op;
        x_pos <= cx;
        y_pos <= cy;
        glyph_column <= ccol;
        attribute <= cattr;
        read_index <= cidx;
        start <= 1'b1;
        @(posedge clk);
        // busy is read before this edge's updates land, i.e. as the block saw it
        while (busy)
            @(posedge clk);

        hit = (cx < SCREEN_WIDTH) && (cy < SCREEN_HEIGHT);
        if ((c_op == OP_SET || c_op == OP_CLR) && hit)
            n_pixel++;
        else if (c_op == OP_DRAW && hit)
            n_draw++;
        else if (c_op == OP_READ)
            n_read++;
        else if (c_op == OP_CLEAR)
            n_clear++;
        else
            n_ignored++;
        if (c_op == OP_READ || c_op == OP_CLEAR || (hit && c_op <= OP_DRAW))
            useful_beats++;
        if (c_op <= OP_DRAW)
            last_index = cx + SCREEN_WIDTH * (cy / PAGE_ROWS);
    endtask

    // Drop start for a random gap: mostly none or short, a few long, none in a burst
    task automatic idle_gap();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (burst || roll < 40)
            gap = 0;
        else if (roll < 85)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(13, 48);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int         roll;
        int         sel;
        int         idx;
        int         base;
        logic [7:0] gx;
        logic [7:0] gy;
        logic [1:0] gattr;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners, every op, attributes, page spill, clipping, bad reads
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd0);   // cleared at reset
        issue(OP_SET,   8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd0);
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd0);
        issue(OP_SET,   8'd83,  8'd47,  8'h00, ATTR_NORMAL,    9'd0);   // bottom-right pixel
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd503);
        idle_gap();
        issue(OP_CLR,   8'd0,   8'd0,   8'hff, ATTR_NORMAL,    9'd0);
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd0);
        issue(OP_DRAW,  8'd10,  8'd0,   8'ha5, ATTR_NORMAL,    9'd0);   // page aligned
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd10);
        issue(OP_DRAW,  8'd20,  8'd13,  8'h3c, ATTR_UNDERLINE, 9'd0);   // straddles two pages
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd104);
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd188);
        idle_gap();
        issue(OP_DRAW,  8'd30,  8'd45,  8'hff, ATTR_SPARE,     9'd0);   // last page, spill dropped
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd450);
        issue(OP_DRAW,  8'd40,  8'd8,   8'h0f, ATTR_INVERSE,   9'd0);
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd124);
        issue(OP_DRAW,  8'd84,  8'd0,   8'hff, ATTR_NORMAL,    9'd0);   // past the right edge
        issue(OP_DRAW,  8'd5,   8'd48,  8'hff, ATTR_NORMAL,    9'd0);   // below the bottom
        issue(OP_SET,   8'd255, 8'd255, 8'hff, ATTR_SPARE,     9'd511);
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd84);
        issue(OP_READ,  8'hff,  8'hff,  8'hff, ATTR_SPARE,     9'd511); // beyond the store
        issue(OP_SPARE_HI, 8'd1, 8'd1,  8'hff, ATTR_NORMAL,    9'd0);   // unused code
        issue(OP_CLEAR, 8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd0);
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd503);
        issue(OP_READ,  8'd0,   8'd0,   8'h00, ATTR_NORMAL,    9'd104);
        idle_gap();

        // Random: mix glyph runs with readback and single scattered commands
        while (useful_beats < TARGET_BEATS)
        begin
            if ($urandom_range(0, 99) < 3)
                burst = !burst;
            roll = $urandom_range(0, 99);
            if (roll < 30)
            begin
                // Draw a glyph a column at a time, then read back every byte it touched
                gx = pick_coord(SCREEN_WIDTH);
                gy = pick_coord(SCREEN_HEIGHT);
                gattr = 2'($urandom_range(0, 3));
                for (int k = 0; k < GLYPH_WIDTH; k++)
                begin
                    issue(OP_DRAW, 8'(gx + k), gy, 8'($urandom_range(0, 255)), gattr,
                          9'($urandom_range(0, 511)));
                    idle_gap();
                end
                base = gx + SCREEN_WIDTH * (gy / PAGE_ROWS);
                for (int k = 0; k < GLYPH_WIDTH; k++)
                    for (int p = 0; p < 2; p++)
                    begin
                        idx = base + k + p * SCREEN_WIDTH;
                        if (idx < STORE_DEPTH && (p == 0 || gy % PAGE_ROWS != 0))
                        begin
                            issue(OP_READ, 8'($urandom_range(0, 255)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  2'($urandom_range(0, 3)), 9'(idx));
                            idle_gap();
                        end
                    end
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 22)
                    issue($urandom_range(0, 1) ? OP_SET : OP_CLR,
                          pick_coord(SCREEN_WIDTH), pick_coord(SCREEN_HEIGHT),
                          8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          9'($urandom_range(0, 511)));
                else if (sel < 40)
                    issue(OP_DRAW, pick_coord(SCREEN_WIDTH), pick_coord(SCREEN_HEIGHT),
                          8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          9'($urandom_range(0, 511)));
                else if (sel < 86)
                begin
                    // Aim reads at the last touched byte or its spill, else anywhere
                    roll = $urandom_range(0, 99);
                    if (roll < 35 && last_index < STORE_DEPTH)
                        idx = last_index;
                    else if (roll < 50 && last_index + SCREEN_WIDTH < STORE_DEPTH)
                        idx = last_index + SCREEN_WIDTH;
                    else if (roll < 95)
                        idx = $urandom_range(0, STORE_DEPTH - 1);
                    else
                        idx = $urandom_range(0, 511);
                    issue(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), 9'(idx));
                end
                else if (sel < 88)
                    issue(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          9'($urandom_range(0, 511)));
                else
                    issue(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                          9'($urandom_range(0, 511)));
                idle_gap();
            end
        end

        // Drain: wait for outstanding reads, then let a final clear-all finish
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Drove %0d pixel writes, %0d column draws, %0d clear-alls, %0d dropped beats",
                 n_pixel, n_draw, n_clear, n_ignored);
        $display("Compared %0d of %0d readback beats with the predicted framebuffer",
                 reads_checked, n_read);
        if (errors == 0)
            $display("page_framebuffer_draw_top test passed");
        else
            $display("page_framebuffer_draw_top test failed");
        $finish;
    end

endmodule
